// ----- rtl/core/csa_pkg.sv -----
// Shared types and codes for the contiguous segment allocator.
package csa_pkg;

  localparam int ADDR_WIDTH = 16;
  localparam int ID_WIDTH   = 8;

  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_COMPACT = 2'd2;
  localparam logic [1:0] OP_INVALID = 2'd3;

  localparam logic [1:0] FIT_FIRST   = 2'd0;
  localparam logic [1:0] FIT_BEST    = 2'd1;
  localparam logic [1:0] FIT_WORST   = 2'd2;
  localparam logic [1:0] FIT_INVALID = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BAD_REQ = 2'd3;

  // one-hot command codes for the cells
  typedef enum logic [3:0] {
    CMD_IDLE    = 4'b0001,
    CMD_RELEASE = 4'b0010,
    CMD_SPLIT   = 4'b0100,
    CMD_COMPACT = 4'b1000
  } cmd_t;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_APPLY   = 6'b000100,
    S_RELEASE = 6'b001000,
    S_COMPACT = 6'b010000,
    S_RESULT  = 6'b100000
  } state_t;

endpackage

// ----- rtl/core/csa_cell.sv -----
// One table entry: holds a segment and shifts it to its neighbour on command.
module csa_cell import csa_pkg::*; #(
  parameter int AW  = 16,
  parameter int IW  = 8
) (
  input  logic          clk,
  // load an explicit value (init, pick write, split tail, compact write)
  input  logic          load,
  input  logic          load_hole,
  input  logic [IW-1:0] load_owner,
  input  logic [AW-1:0] load_start,
  input  logic [AW-1:0] load_last,
  // shift in from lower neighbour
  input  logic          shift,
  input  logic          prev_hole,
  input  logic [IW-1:0] prev_owner,
  input  logic [AW-1:0] prev_start,
  input  logic [AW-1:0] prev_last,
  // free in place
  input  logic          free_it,
  output logic          hole,
  output logic [IW-1:0] owner,
  output logic [AW-1:0] seg_start,
  output logic [AW-1:0] seg_last
);

  always_ff @(posedge clk) begin
    if (load) begin
      hole      <= load_hole;
      owner     <= load_owner;
      seg_start <= load_start;
      seg_last  <= load_last;
    end else if (shift) begin
      hole      <= prev_hole;
      owner     <= prev_owner;
      seg_start <= prev_start;
      seg_last  <= prev_last;
    end else if (free_it) begin
      hole <= 1'b1;
    end
  end

endmodule

// ----- rtl/core/contiguous_segment_allocator.sv -----
// Segment allocator: a row of table cells driven by a sequencing controller.
// A request reads one cell per scan cycle, then splits the picked hole in the
// apply state, shifting the upper cells; release and compact walk the table
// once. One request in flight; the output register frees the input while a
// result waits. Reset (synchronous) sets memory to 2^AW units held as one
// hole; a memory_size write does the same with its size.
module contiguous_segment_allocator import csa_pkg::*; #(
  parameter int MAX_SEGMENTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[1:0], process_id[9:2], request_size[26:10], fit_strategy[28:27]
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], alloc_start[17:2], freed_count[23:18]
  output logic [23:0] m_axis_tdata
);

  localparam int N  = MAX_SEGMENTS;
  localparam int IX = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam int AW = ADDR_WIDTH;
  localparam int IW = ID_WIDTH;

  state_t state;
  logic [AW:0]   mem_size;
  logic [CW-1:0] seg_count;
  logic [CW-1:0] idx;
  logic [1:0]    strat;
  logic [IW-1:0] pid;
  logic [16:0]   rsize;
  logic          found;
  logic [IX-1:0] pick;
  logic [AW:0]   pick_len;
  logic [CW-1:0] freed;
  logic [1:0]    res_status;
  logic [15:0]   res_start;
  logic [CW-1:0] wptr;
  logic [AW:0]   nxt;

  logic          c_hole [N];
  logic [IW-1:0] c_owner[N];
  logic [AW-1:0] c_start[N];
  logic [AW-1:0] c_last [N];
  logic          l_en [N];
  logic          l_hole [N];
  logic [IW-1:0] l_owner[N];
  logic [AW-1:0] l_start[N];
  logic [AW-1:0] l_last [N];
  logic          sh_en[N];
  logic          fr_en[N];

  logic init_req;
  logic [AW:0] cfg_size;
  always_comb begin
    if (cfg_wdata == 17'd0) cfg_size = (AW+1)'(1);
    else if ({15'd0, cfg_wdata} > (32'd1 << AW)) cfg_size = (AW+1)'(1) << AW;
    else cfg_size = (AW+1)'(cfg_wdata);
  end
  assign init_req = rst | cfg_we;
  logic [AW:0] init_size;
  assign init_size = rst ? ((AW+1)'(1) << AW) : cfg_size;

  // current scan entry
  logic [IX-1:0] ci;
  logic [AW:0]   cur_len;
  logic          in_range;
  assign ci       = idx[IX-1:0];
  assign in_range = idx < seg_count;
  assign cur_len  = {1'b0, c_last[ci]} - {1'b0, c_start[ci]} + (AW+1)'(1);

  logic [AW:0] pick_end;
  assign pick_end = {1'b0, c_start[pick]} + (AW+1)'(rsize);

  // a split only happens below a full table, so pick+1 is always a valid entry
  logic [IX-1:0] pick_nx;
  assign pick_nx = pick + IX'(1);

  always_comb begin
    for (int k = 0; k < N; k++) begin
      l_en[k] = 1'b0; l_hole[k] = 1'b0; l_owner[k] = pid;
      l_start[k] = '0; l_last[k] = '0; sh_en[k] = 1'b0; fr_en[k] = 1'b0;
    end
    if (init_req) begin
      l_en[0] = 1'b1; l_hole[0] = 1'b1;
      l_last[0] = AW'(init_size - (AW+1)'(1));
    end else if (state == S_APPLY && found) begin
      if (pick_len == (AW+1)'(rsize)) begin
        l_en[pick] = 1'b1; l_hole[pick] = 1'b0;
        l_start[pick] = c_start[pick]; l_last[pick] = c_last[pick];
      end else if (seg_count < CW'(N)) begin
        for (int k = 0; k < N; k++)
          if (k > int'(pick) + 1) sh_en[k] = 1'b1;
        l_en[pick] = 1'b1; l_hole[pick] = 1'b0;
        l_start[pick] = c_start[pick]; l_last[pick] = AW'(pick_end - (AW+1)'(1));
        l_en[pick_nx] = 1'b1; l_hole[pick_nx] = 1'b1;
        l_start[pick_nx] = AW'(pick_end); l_last[pick_nx] = c_last[pick];
      end
    end else if (state == S_RELEASE && in_range) begin
      if (!c_hole[ci] && c_owner[ci] == pid) fr_en[ci] = 1'b1;
    end else if (state == S_COMPACT) begin
      if (in_range && !c_hole[ci]) begin
        l_en[wptr[IX-1:0]] = 1'b1; l_hole[wptr[IX-1:0]] = 1'b0;
        l_owner[wptr[IX-1:0]] = c_owner[ci];
        l_start[wptr[IX-1:0]] = AW'(nxt);
        l_last[wptr[IX-1:0]] = AW'(nxt + cur_len - (AW+1)'(1));
      end else if (!in_range && nxt < mem_size && wptr < CW'(N)) begin
        l_en[wptr[IX-1:0]] = 1'b1; l_hole[wptr[IX-1:0]] = 1'b1;
        l_start[wptr[IX-1:0]] = AW'(nxt);
        l_last[wptr[IX-1:0]] = AW'(mem_size - (AW+1)'(1));
      end
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    csa_cell #(.AW(AW), .IW(IW)) u_cell (
      .clk,
      .load(l_en[g]), .load_hole(l_hole[g]), .load_owner(l_owner[g]),
      .load_start(l_start[g]), .load_last(l_last[g]),
      .shift(sh_en[g]),
      .prev_hole (c_hole [g == 0 ? 0 : g-1]),
      .prev_owner(c_owner[g == 0 ? 0 : g-1]),
      .prev_start(c_start[g == 0 ? 0 : g-1]),
      .prev_last (c_last [g == 0 ? 0 : g-1]),
      .free_it(fr_en[g]),
      .hole(c_hole[g]), .owner(c_owner[g]),
      .seg_start(c_start[g]), .seg_last(c_last[g])
    );
  end

  assign s_axis_tready = (state == S_IDLE) && !cfg_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      mem_size <= (AW+1)'(1) << AW;
      seg_count <= CW'(1);
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_RESULT) m_axis_tvalid <= 1'b0;
      if (cfg_we) begin
        mem_size <= cfg_size;
        seg_count <= CW'(1);
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            pid <= s_axis_tdata[2 +: IW];
            rsize <= s_axis_tdata[26:10];
            strat <= s_axis_tdata[28:27];
            idx <= '0; found <= 1'b0; freed <= '0; wptr <= '0; nxt <= '0;
            res_start <= '0; res_status <= ST_OK;
            case (s_axis_tdata[1:0])
              OP_REQUEST: begin
                if (s_axis_tdata[26:10] == 17'd0 || s_axis_tdata[28:27] == FIT_INVALID) begin
                  res_status <= ST_BAD_REQ; state <= S_RESULT;
                end else state <= S_SCAN;
              end
              OP_RELEASE: state <= S_RELEASE;
              OP_COMPACT: state <= S_COMPACT;
              default: begin res_status <= ST_BAD_REQ; state <= S_RESULT; end
            endcase
          end
        end
        S_SCAN: begin
          if (!in_range || (found && strat == FIT_FIRST)) state <= S_APPLY;
          else begin
            if (c_hole[ci] && cur_len >= (AW+1)'(rsize) &&
                (!found || (strat == FIT_BEST && cur_len < pick_len) ||
                 (strat == FIT_WORST && cur_len > pick_len))) begin
              found <= 1'b1; pick <= ci; pick_len <= cur_len;
            end
            idx <= idx + CW'(1);
          end
        end
        S_APPLY: begin
          state <= S_RESULT;
          if (!found) res_status <= ST_NO_FIT;
          else if (pick_len == (AW+1)'(rsize)) res_start <= 16'(c_start[pick]);
          else if (seg_count >= CW'(N)) res_status <= ST_FULL;
          else begin
            res_start <= 16'(c_start[pick]);
            seg_count <= seg_count + CW'(1);
          end
        end
        S_RELEASE: begin
          if (!in_range) state <= S_RESULT;
          else begin
            if (fr_en[ci]) freed <= freed + CW'(1);
            idx <= idx + CW'(1);
          end
        end
        S_COMPACT: begin
          if (in_range) begin
            if (!c_hole[ci]) begin
              wptr <= wptr + CW'(1);
              nxt <= nxt + cur_len;
            end
            idx <= idx + CW'(1);
          end else begin
            seg_count <= (nxt < mem_size && wptr < CW'(N)) ? wptr + CW'(1) : wptr;
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          // hold here until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= {6'(freed), res_start, res_status};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/segment_checker.sv -----
// Checker: predicts allocator responses and compares them with the output stream.
`timescale 1ns / 100ps
module segment_checker import csa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  output int          mismatches,
  output int          responses_seen,
  output int          pending
);
  localparam int NSEG = 32;

  // packed from the top bit down: freed, start, status
  typedef struct packed {
    logic [5:0]  freed;
    logic [15:0] start;
    logic [1:0]  status;
  } resp_t;

  logic [7:0]  tbl_owner [NSEG];
  logic        tbl_hole  [NSEG];
  logic [16:0] tbl_first [NSEG];
  logic [16:0] tbl_final [NSEG];
  int          tbl_used;
  logic [16:0] mem_units;
  resp_t       expected_resps[$];

  assign pending = expected_resps.size();

  function automatic void clear_table();
    tbl_hole[0]  = 1'b1;
    tbl_first[0] = '0;
    tbl_final[0] = mem_units - 17'd1;
    tbl_owner[0] = '0;
    tbl_used     = 1;
  endfunction

  function automatic resp_t apply_request(logic [31:0] d);
    resp_t r;
    logic [1:0]  op;
    logic [7:0]  id;
    logic [16:0] size;
    logic [1:0]  fit;
    logic [16:0] len, pick_len;
    int pick;
    bit found;
    int w;
    logic [16:0] nxt;
    r = '0;
    op = d[1:0]; id = d[9:2]; size = d[26:10]; fit = d[28:27];
    pick = 0; found = 0; pick_len = 0;
    case (op)
      OP_REQUEST: begin
        if (size == 0 || fit > FIT_WORST) begin
          r.status = ST_BAD_REQ;
          return r;
        end
        for (int i = 0; i < tbl_used; i++) begin
          if (!tbl_hole[i]) continue;
          len = tbl_final[i] - tbl_first[i] + 17'd1;
          if (len < size) continue;
          if (!found || (fit == FIT_BEST && len < pick_len) ||
              (fit == FIT_WORST && len > pick_len)) begin
            found = 1; pick = i; pick_len = len;
            if (fit == FIT_FIRST) break;
          end
        end
        if (!found) begin
          r.status = ST_NO_FIT;
        end else if (pick_len == size) begin
          tbl_hole[pick] = 0; tbl_owner[pick] = id;
          r.start = tbl_first[pick][15:0];
        end else if (tbl_used >= NSEG) begin
          r.status = ST_FULL;
        end else begin
          for (int i = tbl_used; i > pick; i--) begin
            tbl_owner[i] = tbl_owner[i-1]; tbl_hole[i] = tbl_hole[i-1];
            tbl_first[i] = tbl_first[i-1]; tbl_final[i] = tbl_final[i-1];
          end
          tbl_used++;
          tbl_hole[pick] = 0; tbl_owner[pick] = id;
          tbl_final[pick] = tbl_first[pick] + size - 17'd1;
          tbl_first[pick+1] = tbl_final[pick] + 17'd1;
          r.start = tbl_first[pick][15:0];
        end
      end
      OP_RELEASE: begin
        for (int i = 0; i < tbl_used; i++)
          if (!tbl_hole[i] && tbl_owner[i] == id) begin
            tbl_hole[i] = 1; r.freed++;
          end
      end
      OP_COMPACT: begin
        w = 0; nxt = 0;
        for (int i = 0; i < tbl_used; i++) begin
          if (tbl_hole[i]) continue;
          len = tbl_final[i] - tbl_first[i] + 17'd1;
          tbl_owner[w] = tbl_owner[i]; tbl_hole[w] = 0;
          tbl_first[w] = nxt; tbl_final[w] = nxt + len - 17'd1;
          nxt += len; w++;
        end
        if (nxt < mem_units && w < NSEG) begin
          tbl_hole[w] = 1; tbl_first[w] = nxt; tbl_final[w] = mem_units - 17'd1;
          w++;
        end
        tbl_used = w;
      end
      default: r.status = ST_BAD_REQ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    resp_t got, want;
    if (rst) begin
      mismatches <= 0;
      responses_seen <= 0;
      expected_resps.delete();
      mem_units = 17'h10000;
      clear_table();
    end else begin
      if (cfg_we) begin
        if (cfg_wdata == 0) mem_units = 17'd1;
        else if (cfg_wdata > 17'h10000) mem_units = 17'h10000;
        else mem_units = cfg_wdata;
        clear_table();
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_resps.push_back(apply_request(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        responses_seen <= responses_seen + 1;
        if (expected_resps.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected response %h at %0t", got, $realtime);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_resps.pop_front();
          if (got != want) begin
            if (mismatches < 10)
              $display({"response %0d: status exp %0d got %0d, start exp %0d got %0d,",
                        " freed exp %0d got %0d"},
                       responses_seen, want.status, got.status, want.start, got.start,
                       want.freed, got.freed);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end
endmodule

// ----- tb/testbench.sv -----
// Top of the allocator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench import csa_pkg::*;;
  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [16:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [23:0] m_axis_tdata;
  int          mismatches, responses_seen, pending;
  int          cycles = 0;
  int          requests_sent = 0;
  bit          hold_off = 0;
  int          cur_mem = 65536;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  contiguous_segment_allocator u_top (.*);

  segment_checker u_chk (.*);

  function automatic int gap_len();
    int p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // called at a falling edge; leaves the request offered until the next call
  task automatic send(logic [1:0] op, logic [7:0] id, logic [16:0] size, logic [1:0] fit);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {3'b0, fit, size, id, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic set_memory(logic [16:0] units);
    s_axis_tvalid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    cfg_we <= 1; cfg_wdata <= units;
    @(negedge clk);
    cfg_we <= 0;
    cur_mem = (units == 0) ? 1 : (units > 17'h10000 ? 65536 : units);
  endtask

  function automatic logic [16:0] pick_size();
    int p = $urandom_range(0, 99);
    if (p < 3) return 17'd0;
    if (p < 6) return 17'($urandom_range(0, 131071));
    if (p < 12) return 17'(cur_mem);
    return 17'($urandom_range(1, (cur_mem > 16) ? cur_mem / 8 : cur_mem));
  endfunction

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (rst || hold_off) m_axis_tready <= 1'b0;
    else if ($urandom_range(0, 99) < 8) m_axis_tready <= 1'b0;
    else m_axis_tready <= (gap_len() == 0) || ($urandom_range(0, 1) == 1);
  end

  initial begin
    wait (requests_sent > 150);
    @(posedge clk);
    hold_off = 1;
    repeat (400) @(posedge clk);
    hold_off = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 600000) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [1:0] op;
    int p;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: extremes, each opcode, bad codes, ties, full table
    send(OP_REQUEST, 8'h00, 17'd0, FIT_FIRST);
    send(OP_REQUEST, 8'hff, 17'd5, FIT_INVALID);
    send(OP_INVALID, 8'h12, 17'd7, FIT_FIRST);
    send(OP_REQUEST, 8'hff, 17'h1ffff, FIT_BEST);
    send(OP_REQUEST, 8'h01, 17'd100, FIT_FIRST);
    send(OP_REQUEST, 8'h02, 17'd100, FIT_FIRST);
    send(OP_REQUEST, 8'h03, 17'd100, FIT_FIRST);
    send(OP_RELEASE, 8'h01, 17'd0, FIT_FIRST);
    send(OP_RELEASE, 8'h03, 17'd0, FIT_FIRST);
    send(OP_REQUEST, 8'h04, 17'd50, FIT_BEST);
    send(OP_REQUEST, 8'h05, 17'd50, FIT_WORST);
    send(OP_RELEASE, 8'h99, 17'd0, FIT_FIRST);
    send(OP_COMPACT, 8'h00, 17'd0, FIT_FIRST);
    send(OP_REQUEST, 8'haa, 17'd65236, FIT_FIRST);
    send(OP_COMPACT, 8'h00, 17'd0, FIT_FIRST);
    set_memory(17'd0);
    send(OP_REQUEST, 8'h07, 17'd1, FIT_WORST);
    send(OP_REQUEST, 8'h07, 17'd1, FIT_FIRST);
    set_memory(17'h1ffff);
    for (int i = 0; i < 33; i++) send(OP_REQUEST, 8'(i), 17'd1, FIT_FIRST);
    send(OP_REQUEST, 8'h08, 17'd65504, FIT_BEST);
    send(OP_RELEASE, 8'h08, 17'd0, FIT_FIRST);
    // random phases over several memory sizes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_memory(17'd64);
        1: set_memory(17'd1000);
        2: set_memory(17'h10000);
        3: set_memory(17'd2);
        4: set_memory(17'($urandom_range(1, 65536)));
        default: set_memory(17'd300);
      endcase
      for (int k = 0; k < 85; k++) begin
        p = $urandom_range(0, 99);
        op = (p < 60) ? OP_REQUEST : (p < 85) ? OP_RELEASE : (p < 96) ? OP_COMPACT : OP_INVALID;
        send(op, (p & 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7)),
             pick_size(), ($urandom_range(0, 19) == 0) ? FIT_INVALID : 2'($urandom_range(0, 2)));
      end
    end
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d requests sent, %0d responses checked across several memory sizes",
             requests_sent, responses_seen);
    if (mismatches == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
